>>> rtl/mdio_mgmt_pkg.sv
package mdio_mgmt_pkg;

    localparam int PREAMBLE_LEN_DEF = 32;

    localparam logic [7:0] PRESCALE_RST = 8'd20;

    // Bus access codes carried by each beat.
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Register window word indexes.
    localparam logic [1:0] IDX_STATUS = 2'd0;
    localparam logic [1:0] IDX_CMD    = 2'd2;
    localparam logic [1:0] IDX_DATA   = 2'd3;

    // Bit positions in the command and status words.
    localparam int CMD_VALID_BIT  = 31;
    localparam int CMD_READ_BIT   = 2;
    localparam int CMD_WRITE_BIT  = 1;
    localparam int ST_PENDING_BIT = 2;
    localparam int ST_BUSY_BIT    = 3;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  reg_index;
        logic [31:0] wr_data;
        logic        mdio_in;
    } item_t;

    typedef struct packed {
        logic [31:0] rd_data;
        logic        mdc;
        logic        mdio_out;
        logic        mdio_oe;
    } result_t;

    typedef struct packed {
        logic [4:0]  phy;
        logic [4:0]  regad;
        logic [15:0] data;
        logic        rd;
    } cmd_t;

endpackage

>>> rtl/mdio_mgmt_engine.sv
module mdio_mgmt_engine #(
    parameter int PREAMBLE_LEN = mdio_mgmt_pkg::PREAMBLE_LEN_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    advance,
    input  mdio_mgmt_pkg::item_t    item,
    input  logic [7:0]              prescale,
    output mdio_mgmt_pkg::result_t  result
);

    localparam int FRAME_BITS = PREAMBLE_LEN + 32;
    localparam int CW         = $clog2(FRAME_BITS + 1);
    localparam int SHIFT_AMT  = 32 - PREAMBLE_LEN;
    localparam logic [63:0] FRAME_ONES = ((64'd1 << PREAMBLE_LEN) - 64'd1) << 32;
    localparam logic [CW-1:0] FRAME_COUNT = CW'(FRAME_BITS);
    // Bits left in the frame while the second turnaround bit, the data bits
    // and the turnaround of a read are on the wire.
    localparam logic [CW-1:0] TA_COUNT      = CW'(17);
    localparam logic [CW-1:0] DATA_COUNT    = CW'(16);
    localparam logic [CW-1:0] RELEASE_COUNT = CW'(18);

    logic                  pend_valid_reg, pend_valid_next;
    mdio_mgmt_pkg::cmd_t   pend_reg, pend_next;
    logic                  busy_reg, busy_next;
    logic                  eng_read_reg, eng_read_next;
    logic [63:0]           shift_reg, shift_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [7:0]            div_reg, div_next;
    logic                  mdc_reg, mdc_next;
    logic [17:0]           rdres_reg, rdres_next;

    logic [31:0]           rd;
    logic [31:0]           word;
    logic                  oe;

    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        busy_next       = busy_reg;
        eng_read_next   = eng_read_reg;
        shift_next      = shift_reg;
        count_next      = count_reg;
        div_next        = div_reg;
        mdc_next        = mdc_reg;
        rdres_next      = rdres_reg;
        rd              = '0;
        word            = '0;

        // Register access; reads see the state before this beat.
        case (item.op)
            mdio_mgmt_pkg::OP_READ: begin
                unique case (item.reg_index)
                    mdio_mgmt_pkg::IDX_STATUS: begin
                        rd[mdio_mgmt_pkg::ST_PENDING_BIT] = pend_valid_reg;
                        rd[mdio_mgmt_pkg::ST_BUSY_BIT]    = busy_reg;
                    end
                    mdio_mgmt_pkg::IDX_CMD: begin
                        if (pend_valid_reg) begin
                            rd = {2'b10, pend_reg.phy, pend_reg.regad, pend_reg.data,
                                  1'b0, pend_reg.rd, !pend_reg.rd, 1'b0};
                        end
                    end
                    mdio_mgmt_pkg::IDX_DATA: begin
                        rd = {14'd0, rdres_reg};
                    end
                    default: begin
                    end
                endcase
            end
            mdio_mgmt_pkg::OP_WRITE: begin
                if (item.reg_index == mdio_mgmt_pkg::IDX_CMD
                        && item.wr_data[mdio_mgmt_pkg::CMD_VALID_BIT]
                        && !pend_valid_reg
                        && (item.wr_data[mdio_mgmt_pkg::CMD_READ_BIT]
                            || item.wr_data[mdio_mgmt_pkg::CMD_WRITE_BIT])) begin
                    pend_valid_next = 1'b1;
                    pend_next.phy   = item.wr_data[29:25];
                    pend_next.regad = item.wr_data[24:20];
                    pend_next.data  = item.wr_data[19:4];
                    pend_next.rd    = item.wr_data[mdio_mgmt_pkg::CMD_READ_BIT];
                end
            end
            default: begin
            end
        endcase

        // Serial engine: one MDC half period per prescale+1 beats.
        if (busy_reg) begin
            if (div_reg < prescale) begin
                div_next = div_reg + 8'd1;
            end else begin
                div_next = '0;
                if (!mdc_reg) begin
                    mdc_next = 1'b1;
                    if (eng_read_reg) begin
                        if (count_reg == TA_COUNT && item.mdio_in) begin
                            rdres_next = {2'b11, rdres_reg[15:0]};
                        end else if (count_reg <= DATA_COUNT) begin
                            rdres_next = {rdres_reg[17:16], rdres_reg[14:0], item.mdio_in};
                        end
                    end
                end else begin
                    mdc_next   = 1'b0;
                    shift_next = shift_reg << 1;
                    if (count_reg != '0) begin
                        count_next = count_reg - CW'(1);
                    end
                    if (count_next == '0) begin
                        busy_next = 1'b0;
                    end
                end
            end
        end

        // An idle engine picks up the pending command.
        if (!busy_next && pend_valid_next) begin
            word = {2'b01, pend_next.rd ? 2'b10 : 2'b01, pend_next.phy, pend_next.regad,
                    pend_next.rd ? 18'd0 : {2'b10, pend_next.data}};
            shift_next      = (FRAME_ONES | {32'd0, word}) << SHIFT_AMT;
            count_next      = FRAME_COUNT;
            eng_read_next   = pend_next.rd;
            busy_next       = 1'b1;
            div_next        = '0;
            mdc_next        = 1'b0;
            pend_valid_next = 1'b0;
            if (pend_next.rd) begin
                rdres_next = '0;
            end
        end

        // A read releases MDIO from the turnaround onward.
        oe = busy_next && !(eng_read_next && count_next <= RELEASE_COUNT);
        result.rd_data  = rd;
        result.mdc      = busy_next & mdc_next;
        result.mdio_out = oe & shift_next[63];
        result.mdio_oe  = oe;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            busy_reg       <= 1'b0;
            eng_read_reg   <= 1'b0;
            shift_reg      <= '0;
            count_reg      <= '0;
            div_reg        <= '0;
            mdc_reg        <= 1'b0;
            rdres_reg      <= '0;
        end else if (advance) begin
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
            busy_reg       <= busy_next;
            eng_read_reg   <= eng_read_next;
            shift_reg      <= shift_next;
            count_reg      <= count_next;
            div_reg        <= div_next;
            mdc_reg        <= mdc_next;
            rdres_reg      <= rdres_next;
        end
    end

endmodule

>>> rtl/mdio_management_master_core.sv
// Clause-22 MDIO management master behind a small register window.
// Each input beat is one tick of the management logic and carries an
// optional register access (read or write of STATUS, CMD or DATA) plus the
// sampled level of the MDIO pin. Every input beat yields exactly one output
// beat with the read data and the MDC, MDIO-out and MDIO-enable levels
// after that tick. A valid CMD write queues one command; the serial engine
// then sends preamble, start, opcode, addresses, turnaround and 16 data
// bits, with MDC toggling every prescale+1 ticks.
// The output beat follows in the cycle after its input beat is accepted, and
// one beat is taken every cycle while the receiver keeps up: the engine state
// and the output register update in the same cycle the beat is accepted.
// When the receiver stalls, the finished beat waits in the output register
// and s_tready drops only while that register is full and not being taken;
// the engine advances only on accepted beats, so stalls never distort MDC.
// The APB port sets prescale (address 0) and may be written only while no
// beat is in flight. Reset clears the pending command, stops the engine,
// drives MDC low, releases MDIO and loads prescale with 20.
module mdio_management_master_core #(
    parameter int PREAMBLE_LEN = mdio_mgmt_pkg::PREAMBLE_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] op, [3:2] reg_index, [35:4] wr_data, [36] mdio_in, [39:37] zero
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] rd_data, [32] mdc, [33] mdio_out, [34] mdio_oe, [39:35] zero
    output logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                   accept;
    mdio_mgmt_pkg::item_t   item;
    mdio_mgmt_pkg::result_t result;
    mdio_mgmt_pkg::result_t out_reg;
    logic                   m_valid_reg, m_valid_next;
    logic [7:0]             prescale_reg;

    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? 32'd0 : {24'd0, prescale_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_reg <= mdio_mgmt_pkg::PRESCALE_RST;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            prescale_reg <= pwdata[7:0];
        end
    end

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign item.op        = s_tdata[1:0];
    assign item.reg_index = s_tdata[3:2];
    assign item.wr_data   = s_tdata[35:4];
    assign item.mdio_in   = s_tdata[36];

    mdio_mgmt_engine #(
        .PREAMBLE_LEN(PREAMBLE_LEN)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (accept),
        .item     (item),
        .prescale (prescale_reg),
        .result   (result)
    );

    always_comb begin
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, out_reg.mdio_oe, out_reg.mdio_out, out_reg.mdc, out_reg.rd_data};

endmodule

>>> tb/mdio_management_master_core_test.sv
module mdio_management_master_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRE = mdio_mgmt_pkg::PREAMBLE_LEN_DEF;
    localparam int FRAME_LEN = PRE + 32;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD = 300;
    localparam int MAX_REPORTS = 40;

    // Codes the block treats as idle or ignores, and the APB address of prescale.
    localparam logic [1:0] OP_IDLE    = 2'd0;
    localparam logic [1:0] OP_RSVD    = 2'd3;
    localparam logic [1:0] IDX_UNUSED = 2'd1;
    localparam logic [2:0] ADDR_PRESCALE = 3'd0;

    localparam logic [1:0] OP_READ    = mdio_mgmt_pkg::OP_READ;
    localparam logic [1:0] OP_WRITE   = mdio_mgmt_pkg::OP_WRITE;
    localparam logic [1:0] IDX_STATUS = mdio_mgmt_pkg::IDX_STATUS;
    localparam logic [1:0] IDX_CMD    = mdio_mgmt_pkg::IDX_CMD;
    localparam logic [1:0] IDX_DATA   = mdio_mgmt_pkg::IDX_DATA;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    mdio_management_master_core #(
        .PREAMBLE_LEN(PRE)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Shadow of the block's state, starting at its reset values.
    logic [7:0]  scale_cfg = mdio_mgmt_pkg::PRESCALE_RST;
    logic        cmd_pending = 1'b0;
    logic [4:0]  cmd_phy = '0;
    logic [4:0]  cmd_reg = '0;
    logic [15:0] cmd_data = '0;
    logic        cmd_rd = 1'b0;
    logic        frame_busy = 1'b0;
    logic        frame_rd = 1'b0;
    logic [63:0] frame_bits = '0;
    logic [6:0]  bits_left = '0;
    logic [7:0]  div_cnt = '0;
    logic        mdc_q = 1'b0;
    logic [17:0] rd_capture = '0;

    mdio_mgmt_pkg::item_t   beats_to_send[$];
    mdio_mgmt_pkg::result_t expected_q[$];

    int  n_checked = 0;
    int  n_errors = 0;
    int  n_rd_frames = 0;
    int  n_wr_frames = 0;
    int  n_settings = 1;
    bit  tx_hold = 1'b0;
    bit  ask_long_hold = 1'b0;

    // One management tick: register read from the old state, then the
    // write, then the serial engine, then a pending command may start.
    function automatic mdio_mgmt_pkg::result_t mdio_tick_predict(mdio_mgmt_pkg::item_t it);
        mdio_mgmt_pkg::result_t r;
        logic [31:0] rd;
        logic [31:0] word;
        logic [63:0] ones;
        int          pos;

        rd = '0;
        if (it.op == OP_READ) begin
            case (it.reg_index)
                IDX_STATUS: begin
                    rd[mdio_mgmt_pkg::ST_PENDING_BIT] = cmd_pending;
                    rd[mdio_mgmt_pkg::ST_BUSY_BIT] = frame_busy;
                end
                IDX_CMD: begin
                    if (cmd_pending) begin
                        rd[mdio_mgmt_pkg::CMD_VALID_BIT] = 1'b1;
                        rd[29:25] = cmd_phy;
                        rd[24:20] = cmd_reg;
                        rd[19:4] = cmd_data;
                        rd[mdio_mgmt_pkg::CMD_READ_BIT] = cmd_rd;
                        rd[mdio_mgmt_pkg::CMD_WRITE_BIT] = !cmd_rd;
                    end
                end
                IDX_DATA: rd[17:0] = rd_capture;
                default: rd = '0;
            endcase
        end else if (it.op == OP_WRITE && it.reg_index == IDX_CMD) begin
            if (it.wr_data[mdio_mgmt_pkg::CMD_VALID_BIT] && !cmd_pending &&
                (it.wr_data[mdio_mgmt_pkg::CMD_READ_BIT] ||
                 it.wr_data[mdio_mgmt_pkg::CMD_WRITE_BIT])) begin
                cmd_pending = 1'b1;
                cmd_phy = it.wr_data[29:25];
                cmd_reg = it.wr_data[24:20];
                cmd_data = it.wr_data[19:4];
                cmd_rd = it.wr_data[mdio_mgmt_pkg::CMD_READ_BIT];
            end
        end

        if (frame_busy) begin
            if (div_cnt < scale_cfg) begin
                div_cnt = div_cnt + 8'd1;
            end else begin
                div_cnt = '0;
                pos = FRAME_LEN - int'(bits_left);
                if (!mdc_q) begin
                    mdc_q = 1'b1;
                    if (frame_rd) begin
                        // A PHY that answers pulls the second turnaround bit low.
                        if (pos == PRE + 15 && it.mdio_in)
                            rd_capture[17:16] = 2'b11;
                        else if (pos >= PRE + 16)
                            rd_capture[15:0] = {rd_capture[14:0], it.mdio_in};
                    end
                end else begin
                    mdc_q = 1'b0;
                    frame_bits = frame_bits << 1;
                    if (bits_left > 0)
                        bits_left = bits_left - 7'd1;
                    if (bits_left == 0)
                        frame_busy = 1'b0;
                end
            end
        end

        if (!frame_busy && cmd_pending) begin
            word = 32'h4000_0000 | (cmd_rd ? 32'h2000_0000 : 32'h1000_0000);
            word[27:23] = cmd_phy;
            word[22:18] = cmd_reg;
            if (!cmd_rd) begin
                word[17] = 1'b1;
                word[15:0] = cmd_data;
            end
            ones = (64'd1 << PRE) - 64'd1;
            frame_bits = ((ones << 32) | {32'd0, word}) << (32 - PRE);
            bits_left = 7'(FRAME_LEN);
            frame_rd = cmd_rd;
            frame_busy = 1'b1;
            div_cnt = '0;
            mdc_q = 1'b0;
            if (cmd_rd) begin
                rd_capture = '0;
                n_rd_frames++;
            end else begin
                n_wr_frames++;
            end
            cmd_pending = 1'b0;
        end

        r.rd_data = rd;
        r.mdc = frame_busy & mdc_q;
        r.mdio_oe = frame_busy && !(frame_rd && (FRAME_LEN - int'(bits_left)) >= PRE + 14);
        r.mdio_out = r.mdio_oe & frame_bits[63];
        return r;
    endfunction

    // Sender: bursts of beats separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin
        bit go;
        mdio_mgmt_pkg::item_t b;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                b = beats_to_send.pop_front();
                expected_q.push_back(mdio_tick_predict(b));
                if (burst_left > 0)
                    burst_left--;
            end
            // A beat on offer stays put until it is taken.
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                go = gap_left == 0 && burst_left > 0 && beats_to_send.size() > 0 && !tx_hold;
                s_tvalid <= go;
                if (go) begin
                    b = beats_to_send[0];
                    s_tdata <= {3'b000, b.mdio_in, b.wr_data, b.reg_index, b.op};
                end
            end
        end
    end

    // Receiver: picks a new random stall behavior each time its mode count runs out.
    int hold_cnt = 0;
    int stall_mode = 0;
    int mode_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (ask_long_hold) begin
                ask_long_hold = 1'b0;
                hold_cnt = LONG_HOLD;
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= mode_left[0];
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        mdio_mgmt_pkg::result_t got;
        mdio_mgmt_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.rd_data = m_tdata[31:0];
            got.mdc = m_tdata[32];
            got.mdio_out = m_tdata[33];
            got.mdio_oe = m_tdata[34];
            if (expected_q.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%t: unexpected result beat %h", $realtime, m_tdata);
            end else begin
                want = expected_q.pop_front();
                n_checked++;
                if (got.rd_data !== want.rd_data || got.mdc !== want.mdc ||
                    got.mdio_out !== want.mdio_out || got.mdio_oe !== want.mdio_oe) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display({"%t: beat %0d expected rd_data=%h mdc=%b out=%b oe=%b,",
                                  " got rd_data=%h mdc=%b out=%b oe=%b"},
                                 $realtime, n_checked, want.rd_data, want.mdc, want.mdio_out,
                                 want.mdio_oe, got.rd_data, got.mdc, got.mdio_out,
                                 got.mdio_oe);
                end
            end
        end
    end

    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%t: no beat moved for %0d cycles, %0d beats still expected",
                         $realtime, WATCHDOG_LIMIT, expected_q.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic add_beat(logic [1:0] op, logic [1:0] idx, logic [31:0] wd, logic din);
        mdio_mgmt_pkg::item_t b;
        b.op = op;
        b.reg_index = idx;
        b.wr_data = wd;
        b.mdio_in = din;
        beats_to_send.push_back(b);
    endtask

    // Mostly a command followed by a run of polls, idle ticks and stray accesses,
    // the rest single beats drawn from the same mix.
    task automatic queue_traffic(int n);
        int          target;
        int          len;
        int          r;
        logic [31:0] wd;

        target = beats_to_send.size() + n;
        while (beats_to_send.size() < target) begin
            if ($urandom_range(0, 9) < 8) begin
                wd = $urandom;
                wd[mdio_mgmt_pkg::CMD_VALID_BIT] = 1'b1;
                r = $urandom_range(0, 9);
                if (r < 4)
                    wd[2:1] = 2'b10;
                else if (r < 8)
                    wd[2:1] = 2'b01;
                else if (r == 8)
                    wd[2:1] = 2'b11;
                else
                    wd[2:1] = 2'b00;
                add_beat(OP_WRITE, IDX_CMD, wd, 1'($urandom_range(0, 1)));
                len = $urandom_range(8, 160);
            end else begin
                len = 1;
            end
            repeat (len) begin
                r = $urandom_range(0, 99);
                wd = $urandom;
                if (r < 55)
                    add_beat(OP_IDLE, 2'($urandom), wd, 1'($urandom_range(0, 1)));
                else if (r < 72)
                    add_beat(OP_READ, IDX_STATUS, wd, 1'($urandom_range(0, 1)));
                else if (r < 82)
                    add_beat(OP_READ, IDX_DATA, wd, 1'($urandom_range(0, 1)));
                else if (r < 88)
                    add_beat(OP_READ, IDX_CMD, wd, 1'($urandom_range(0, 1)));
                else if (r < 92)
                    add_beat(OP_WRITE, IDX_CMD, wd, 1'($urandom_range(0, 1)));
                else if (r < 95)
                    add_beat(OP_RSVD, 2'($urandom), wd, 1'($urandom_range(0, 1)));
                else if (r < 97)
                    add_beat(OP_READ, IDX_UNUSED, wd, 1'($urandom_range(0, 1)));
                else
                    add_beat(OP_WRITE, ($urandom_range(0, 1) ? IDX_STATUS : IDX_DATA),
                             wd, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic wait_drained();
        while (beats_to_send.size() != 0 || s_tvalid || expected_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic set_prescale(logic [7:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_PRESCALE;
        pwdata <= {24'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        scale_cfg = value;
        n_settings++;
        @(negedge aclk);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Register window while idle, then ignored and accepted commands.
        add_beat(OP_READ, IDX_STATUS, 32'h0000_0000, 1'b0);
        add_beat(OP_READ, IDX_CMD, 32'hFFFF_FFFF, 1'b1);
        add_beat(OP_READ, IDX_DATA, 32'h0000_0000, 1'b0);
        add_beat(OP_READ, IDX_UNUSED, 32'hFFFF_FFFF, 1'b1);
        add_beat(OP_RSVD, IDX_CMD, 32'hFFFF_FFFF, 1'b1);
        add_beat(OP_WRITE, IDX_STATUS, 32'hFFFF_FFFF, 1'b0);
        add_beat(OP_WRITE, IDX_DATA, 32'hFFFF_FFFF, 1'b1);
        add_beat(OP_WRITE, IDX_UNUSED, 32'hFFFF_FFFF, 1'b0);
        add_beat(OP_WRITE, IDX_CMD, 32'h7FFF_FFFF, 1'b1);
        add_beat(OP_WRITE, IDX_CMD, 32'hFFFF_FFF9, 1'b0);
        add_beat(OP_READ, IDX_STATUS, 32'h0000_0000, 1'b1);
        // Both opcode bits set: the read wins and starts at once.
        add_beat(OP_WRITE, IDX_CMD, 32'hFFFF_FFFF, 1'b0);
        add_beat(OP_READ, IDX_STATUS, 32'h0000_0000, 1'b0);
        add_beat(OP_WRITE, IDX_CMD, 32'h8000_0002, 1'b1);
        add_beat(OP_READ, IDX_CMD, 32'h0000_0000, 1'b0);
        add_beat(OP_WRITE, IDX_CMD, 32'hFFFF_FFF4, 1'b1);
        add_beat(OP_READ, IDX_CMD, 32'hFFFF_FFFF, 1'b0);
        add_beat(OP_READ, IDX_STATUS, 32'h0000_0000, 1'b1);
        add_beat(OP_READ, IDX_DATA, 32'h0000_0000, 1'b0);
        add_beat(OP_IDLE, IDX_CMD, 32'hFFFF_FFFF, 1'b1);
        add_beat(OP_IDLE, IDX_STATUS, 32'h0000_0000, 1'b0);
        add_beat(OP_READ, IDX_STATUS, 32'hA5A5_5A5A, 1'b1);
        wait_drained();

        // The frame started above is mid-flight, so this lowers the
        // prescale below a running divider.
        set_prescale(8'd0);
        queue_traffic(350);
        ask_long_hold = 1'b1;
        wait_drained();

        set_prescale(8'd1);
        queue_traffic(300);
        while (beats_to_send.size() > 150)
            @(negedge aclk);
        tx_hold = 1'b1;
        while (s_tvalid || expected_q.size() != 0)
            @(negedge aclk);
        tx_hold = 1'b0;
        wait_drained();

        set_prescale(8'd255);
        queue_traffic(100);
        wait_drained();

        set_prescale(8'd3);
        queue_traffic(350);
        wait_drained();

        repeat (8) @(posedge aclk);
        $display("Checked %0d result beats over %0d prescale settings;", n_checked, n_settings);
        $display("the engine ran %0d read frames and %0d write frames.", n_rd_frames,
                 n_wr_frames);
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
